>>> rtl/des_key_schedule_assert.svh
// assertion macros for the des key schedule checker
`ifndef DES_KEY_SCHEDULE_ASSERT_SVH
`define DES_KEY_SCHEDULE_ASSERT_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define DKS_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("des key schedule: same-cycle check failed");

// next-cycle implication, sampled on clk, off while arst_n is low
`define DKS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("des key schedule: next-cycle check failed");

`endif

>>> rtl/dks_pkg.sv
// shared constants, types and permutation functions of the des key schedule
`timescale 1ns / 1ps

package dks_pkg;

	localparam int KEY_W       = 64;
	localparam int SUBKEY_W    = 48;
	localparam int HALF_W      = 28;
	localparam int CD_W        = 2 * HALF_W;
	localparam int ROUNDS      = 16;
	localparam int RIDX_W      = $clog2(ROUNDS);
	localparam int QUEUE_DEPTH = 2;

	localparam logic [RIDX_W-1:0] LAST_ROUND = RIDX_W'(ROUNDS - 1);

	// key permutation into c||d, standard bit numbering counted from the msb
	localparam logic [6:0] PC1_TAB [CD_W] = '{
		7'd57, 7'd49, 7'd41, 7'd33, 7'd25, 7'd17, 7'd9,
		7'd1,  7'd58, 7'd50, 7'd42, 7'd34, 7'd26, 7'd18,
		7'd10, 7'd2,  7'd59, 7'd51, 7'd43, 7'd35, 7'd27,
		7'd19, 7'd11, 7'd3,  7'd60, 7'd52, 7'd44, 7'd36,
		7'd63, 7'd55, 7'd47, 7'd39, 7'd31, 7'd23, 7'd15,
		7'd7,  7'd62, 7'd54, 7'd46, 7'd38, 7'd30, 7'd22,
		7'd14, 7'd6,  7'd61, 7'd53, 7'd45, 7'd37, 7'd29,
		7'd21, 7'd13, 7'd5,  7'd28, 7'd20, 7'd12, 7'd4
	};

	// subkey selection over the joined c/d halves
	localparam logic [5:0] PC2_TAB [SUBKEY_W] = '{
		6'd14, 6'd17, 6'd11, 6'd24, 6'd1,  6'd5,
		6'd3,  6'd28, 6'd15, 6'd6,  6'd21, 6'd10,
		6'd23, 6'd19, 6'd12, 6'd4,  6'd26, 6'd8,
		6'd16, 6'd7,  6'd27, 6'd20, 6'd13, 6'd2,
		6'd41, 6'd52, 6'd31, 6'd37, 6'd47, 6'd55,
		6'd30, 6'd40, 6'd51, 6'd45, 6'd33, 6'd48,
		6'd44, 6'd49, 6'd39, 6'd56, 6'd34, 6'd53,
		6'd46, 6'd42, 6'd50, 6'd36, 6'd29, 6'd32
	};

	// bit r set where round r rotates by two, clear where it rotates by one
	localparam logic [ROUNDS-1:0] ROT_TWO = 16'h7EFC;

	typedef struct packed {
		logic [HALF_W-1:0] c;
		logic [HALF_W-1:0] d;
	} cd_t;

	function automatic cd_t pc1(input logic [KEY_W-1:0] key);
		logic [CD_W-1:0] r;
		cd_t             res;
		for (int i = 0; i < CD_W; i++) begin
			r[CD_W-1-i] = key[KEY_W - int'(PC1_TAB[i])];
		end
		res.c = r[CD_W-1:HALF_W];
		res.d = r[HALF_W-1:0];
		return res;
	endfunction

	function automatic logic [SUBKEY_W-1:0] pc2(input cd_t cd);
		logic [CD_W-1:0]     joined;
		logic [SUBKEY_W-1:0] r;
		joined = cd;
		for (int i = 0; i < SUBKEY_W; i++) begin
			r[SUBKEY_W-1-i] = joined[CD_W - int'(PC2_TAB[i])];
		end
		return r;
	endfunction

	function automatic logic [HALF_W-1:0] rotl_half(input logic [HALF_W-1:0] v,
		input logic two);
		return two ? {v[HALF_W-3:0], v[HALF_W-1:HALF_W-2]} : {v[HALF_W-2:0], v[HALF_W-1]};
	endfunction

endpackage

>>> rtl/dks_front.sv
// front end: takes key requests and registers their parity-stripped c/d halves
`timescale 1ns / 1ps

module dks_front import dks_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  logic [KEY_W-1:0] key_word,
	output logic             q_push,
	input  logic             q_full,
	output cd_t              q_wdata
);

	logic valid_s1;
	cd_t  cd_s1;
	logic take;

	// stage may refill while its content moves into the queue
	assign full    = valid_s1 && q_full;
	assign take    = push && !full;
	assign q_push  = valid_s1;
	assign q_wdata = cd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (!q_full) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cd_s1 <= pc1(key_word);
		end
	end

endmodule

>>> rtl/dks_queue.sv
// short queue of key halves between the front and back ends
`timescale 1ns / 1ps

module dks_queue import dks_pkg::*; #(
	parameter int Depth = QUEUE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cd_t  wdata,
	output logic full,
	input  logic pop,
	output cd_t  rdata,
	output logic empty
);

	localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW = $clog2(Depth + 1);

	cd_t             mem_q [Depth];
	logic [PtrW-1:0] wptr_q;
	logic [PtrW-1:0] rptr_q;
	logic [CntW-1:0] count_q;
	logic            do_push;
	logic            do_pop;

	assign full    = count_q == CntW'(Depth);
	assign empty   = count_q == '0;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rptr_q];

	function automatic logic [PtrW-1:0] next_ptr(input logic [PtrW-1:0] p);
		return (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= next_ptr(wptr_q);
			end
			if (do_pop) begin
				rptr_q <= next_ptr(rptr_q);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wptr_q] <= wdata;
		end
	end

endmodule

>>> rtl/dks_back.sv
// back end: round engine that rotates the halves and registers each subkey
`timescale 1ns / 1ps

module dks_back import dks_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_empty,
	output logic                q_pop,
	input  cd_t                 q_rdata,
	output logic                empty,
	input  logic                pop,
	output logic [SUBKEY_W-1:0] subkey,
	output logic [RIDX_W-1:0]   round_index,
	output logic                last
);

	logic                busy_q;
	logic [RIDX_W-1:0]   round_q;
	cd_t                 cd_q;
	logic                out_valid_q;
	logic [SUBKEY_W-1:0] subkey_q;
	logic [RIDX_W-1:0]   ridx_q;
	logic                last_q;
	logic                step;
	logic                final_step;
	logic                load;
	cd_t                 cd_next;

	assign step       = busy_q && (!out_valid_q || pop);
	assign final_step = step && (round_q == LAST_ROUND);
	assign load       = (!busy_q || final_step) && !q_empty;
	assign q_pop      = load;

	assign cd_next.c = rotl_half(cd_q.c, ROT_TWO[round_q]);
	assign cd_next.d = rotl_half(cd_q.d, ROT_TWO[round_q]);

	assign empty       = !out_valid_q;
	assign subkey      = subkey_q;
	assign round_index = ridx_q;
	assign last        = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			round_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				busy_q  <= 1'b1;
				round_q <= '0;
			end else if (step) begin
				busy_q  <= !final_step;
				round_q <= round_q + 1'b1;
			end
			if (step) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			cd_q <= q_rdata;
		end else if (step) begin
			cd_q <= cd_next;
		end
		if (step) begin
			subkey_q <= pc2(cd_next);
			ridx_q   <= round_q;
			last_q   <= round_q == LAST_ROUND;
		end
	end

endmodule

>>> rtl/des_key_schedule.sv
// top level of the des key schedule: front end, key queue and round engine
`timescale 1ns / 1ps

//  channel   direction  handshake          payload
//  key       in         push / full        key_word[63:0]
//  subkey    out        pop / empty        subkey[47:0], round_index[3:0], last
//
//  one subkey per cycle while pop takes them; the engine loads the next queued key
//  on its last round step, so the subkeys of consecutive keys follow without a gap
//  with the engine idle, a key's first subkey passes the front stage, the queue,
//  the c/d register and the subkey register; asynchronous active-low reset empties
//  the front stage, queue and engine; pop held low stalls only the engine, and the
//  front stage and queue keep taking keys until QueueDepth + 1 keys wait

module des_key_schedule import dks_pkg::*; #(
	parameter int QueueDepth = QUEUE_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  logic [KEY_W-1:0]    key_word,
	output logic                empty,
	input  logic                pop,
	output logic [SUBKEY_W-1:0] subkey,
	output logic [RIDX_W-1:0]   round_index,
	output logic                last
);

	// front to queue
	logic q_push;
	logic q_full;
	cd_t  q_wdata;

	// queue to back
	logic q_pop;
	logic q_empty;
	cd_t  q_rdata;

	// key permutation on the incoming key request, one register stage
	dks_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.key_word (key_word),
		.q_push   (q_push),
		.q_full   (q_full),
		.q_wdata  (q_wdata)
	);

	// decouples key intake from the round engine
	dks_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.full   (q_full),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.empty  (q_empty)
	);

	// rotations, subkey selection and the result register
	dks_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_empty     (q_empty),
		.q_pop       (q_pop),
		.q_rdata     (q_rdata),
		.empty       (empty),
		.pop         (pop),
		.subkey      (subkey),
		.round_index (round_index),
		.last        (last)
	);

endmodule

>>> rtl/dks_checker.sv
// port-level checker of the des key schedule and its bind
`timescale 1ns / 1ps
`include "des_key_schedule_assert.svh"

module dks_checker import dks_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                full,
	input logic                empty,
	input logic                pop,
	input logic [SUBKEY_W-1:0] subkey,
	input logic [RIDX_W-1:0]   round_index,
	input logic                last
);

	logic [RIDX_W-1:0] exp_round_q;

	// rounds come out in order and wrap after the last one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_round_q <= '0;
		end else if (pop && !empty) begin
			exp_round_q <= round_index + 1'b1;
		end
	end

	`DKS_ASSERT_NOW(a_round_order, !empty, round_index == exp_round_q)
	`DKS_ASSERT_NOW(a_last_flag, !empty, last == (round_index == LAST_ROUND))
	`DKS_ASSERT_NEXT(a_result_hold, !empty && !pop, !empty && $stable(subkey) && $stable(last))
	`DKS_ASSERT_NOW(a_flags_known, 1'b1, !$isunknown({full, empty}))
	`DKS_ASSERT_NOW(a_result_known, !empty, !$isunknown({subkey, round_index, last}))

endmodule

bind des_key_schedule dks_checker u_dks_checker (.*);
